// File: src/ddk_pkg.sv
// Package: shared constants and codes for the differential drive kinematics block.
`default_nettype none
package ddk_pkg;

  localparam int Q_W = 32;
  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  // divider: numerator, denominator and quotient widths
  localparam int DIV_NW = 64;
  localparam int DIV_QW = 32;
  localparam int DIV_DW = DIV_NW - DIV_QW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS         = 3'd0,
    CFG_AXLE_HALF      = 3'd1,
    CFG_SPEED_LIMIT    = 3'd2,
    CFG_LEFT_SIGN_NEG  = 3'd3,
    CFG_RIGHT_SIGN_NEG = 3'd4
  } cfg_idx_t;

endpackage
`default_nettype wire

// File: src/ddk_if.sv
// Interfaces: command and result channels of the kinematics block.
`default_nettype none
interface ddk_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_vx;
  logic signed [31:0] target_turn_rate;
  logic               enable;
  logic signed [31:0] measured_left_motor_rate;
  logic signed [31:0] measured_right_motor_rate;

  modport source (output valid, target_vx, target_turn_rate, enable,
                  measured_left_motor_rate, measured_right_motor_rate,
                  input ready);
  modport sink (input valid, target_vx, target_turn_rate, enable,
                measured_left_motor_rate, measured_right_motor_rate,
                output ready);
endinterface

interface ddk_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_motor_target;
  logic signed [31:0] right_motor_target;
  logic               motors_enabled;
  logic signed [31:0] resolved_vx;
  logic signed [31:0] resolved_turn_rate;
  logic signed [31:0] measured_vx;
  logic signed [31:0] measured_turn_rate;
  logic               saturated;

  modport source (output valid, left_motor_target, right_motor_target, motors_enabled,
                  resolved_vx, resolved_turn_rate, measured_vx, measured_turn_rate,
                  saturated, input ready);
  modport sink (input valid, left_motor_target, right_motor_target, motors_enabled,
                resolved_vx, resolved_turn_rate, measured_vx, measured_turn_rate,
                saturated, output ready);
endinterface
`default_nettype wire

// File: src/ddk_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none
module ddk_div (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [ddk_pkg::DIV_NW-1:0] num,
  input  logic [ddk_pkg::DIV_DW-1:0] den,
  output logic [ddk_pkg::DIV_QW-1:0] quo,
  output logic                       ovf
);
  import ddk_pkg::*;

  logic [DIV_DW-1:0] rem      [DIV_QW];
  logic [DIV_QW-1:0] lq       [DIV_QW];
  logic [DIV_DW-1:0] dv       [DIV_QW];
  logic              of       [DIV_QW];
  logic [DIV_DW-1:0] rem_in   [DIV_QW];
  logic [DIV_QW-1:0] lq_in    [DIV_QW];
  logic [DIV_DW-1:0] dv_in    [DIV_QW];
  logic              of_in    [DIV_QW];
  logic [DIV_DW-1:0] rem_next [DIV_QW];
  logic [DIV_QW-1:0] lq_next  [DIV_QW];
  logic [DIV_DW:0]   trial    [DIV_QW];

  always_comb begin
    rem_in[0] = DIV_DW'(num[DIV_NW-1:DIV_QW]);
    lq_in[0]  = num[DIV_QW-1:0];
    dv_in[0]  = den;
    of_in[0]  = DIV_DW'(num[DIV_NW-1:DIV_QW]) >= den;
    for (int k = 1; k < DIV_QW; k++) begin
      rem_in[k] = rem[k-1];
      lq_in[k]  = lq[k-1];
      dv_in[k]  = dv[k-1];
      of_in[k]  = of[k-1];
    end
    for (int k = 0; k < DIV_QW; k++) begin
      trial[k] = {rem_in[k], lq_in[k][DIV_QW-1]};
      if (trial[k] >= {1'b0, dv_in[k]}) begin
        rem_next[k] = DIV_DW'(trial[k] - {1'b0, dv_in[k]});
        lq_next[k]  = {lq_in[k][DIV_QW-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[k][DIV_DW-1:0];
        lq_next[k]  = {lq_in[k][DIV_QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_QW; k++) begin
        rem[k] <= rem_next[k];
        lq[k]  <= lq_next[k];
        dv[k]  <= dv_in[k];
        of[k]  <= of_in[k];
      end
    end
  end

  assign quo = lq[DIV_QW-1];
  assign ovf = of[DIV_QW-1];

endmodule
`default_nettype wire

// File: src/diff_drive_kinematics.sv
// Top level: differential drive inverse/forward kinematics pipeline.
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    target_vx, target_turn_rate, enable, measured rates
//  res      out  valid/ready    motor targets, enable, resolved and measured motion
//  cfg      in   cfg_we         cfg_index, cfg_data
//
// One beat per cycle sustained unless the result stalls; the path passes through two
// 32-stage dividers in series (limit scaling, then speed/radius and turn rate).
// Reset clears valid bits and restores the register defaults.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module diff_drive_kinematics (
  input  logic                           clk,
  input  logic                           rst,
  ddk_cmd_if.sink                        cmd,
  ddk_res_if.source                      res,
  input  logic                           cfg_we,
  input  logic [ddk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddk_pkg::CFG_W-1:0]      cfg_data
);
  import ddk_pkg::*;

  typedef struct packed {
    logic        v;
    logic        en;
    logic [31:0] vl;
    logic [31:0] vr;
    logic        lim;
    logic [31:0] mvx;
    logic [DIV_NW-1:0] nmw;
    logic        dneg;
    logic        clip;
  } sb1_t;

  typedef struct packed {
    logic        v;
    logic        en;
    logic        lneg;
    logic        rneg;
    logic        wneg;
    logic [31:0] rvx;
    logic [31:0] mvx;
    logic        dneg;
    logic        clip;
  } sb2_t;

  function automatic logic [32:0] to_q(input logic neg, input logic [48:0] m);
    if (neg) begin
      if (m > 49'(Q_MIN)) return {1'b1, Q_MIN};
      return {1'b0, 32'(49'd0 - m)};
    end
    if (m > 49'(Q_MAX)) return {1'b1, Q_MAX};
    return {1'b0, m[31:0]};
  endfunction

  function automatic logic [32:0] neg_sat(input logic [31:0] v, input logic neg);
    if (neg) begin
      if (v == Q_MIN) return {1'b1, Q_MAX};
      return {1'b0, 32'd0 - v};
    end
    return {1'b0, v};
  endfunction

  function automatic logic [32:0] sat33(input logic [32:0] s);
    if (s[32] != s[31]) return {1'b1, (s[32] ? Q_MIN : Q_MAX)};
    return {1'b0, s[31:0]};
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  function automatic logic [32:0] abs33(input logic [32:0] v);
    return v[32] ? 33'd0 - v : v;
  endfunction

  // (|a+b|+1)>>1 with sign; the result always fits
  function automatic logic [31:0] half_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    logic [33:0] h;
    s = {a[31], a} + {b[31], b};
    h = (34'(abs33(s)) + 34'd1) >> 1;
    return s[32] ? 32'd0 - h[31:0] : h[31:0];
  endfunction

  // configuration
  logic [CFG_W-1:0] rad_cfg, axle_half, speed_limit;
  logic             left_sign_negative, right_sign_negative;

  always_ff @(posedge clk) begin
    if (rst) begin
      rad_cfg             <= 31'd65536;
      axle_half           <= 31'd65536;
      speed_limit         <= '0;
      left_sign_negative  <= 1'b0;
      right_sign_negative <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RADIUS:         rad_cfg             <= cfg_data;
        CFG_AXLE_HALF:      axle_half           <= cfg_data;
        CFG_SPEED_LIMIT:    speed_limit         <= cfg_data;
        CFG_LEFT_SIGN_NEG:  left_sign_negative  <= cfg_data[0];
        CFG_RIGHT_SIGN_NEG: right_sign_negative <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] rad_eff, ht_eff;
  logic [31:0]      track2;
  assign rad_eff = (rad_cfg == '0) ? 31'd1 : rad_cfg;
  assign ht_eff  = (axle_half == '0) ? 31'd1 : axle_half;
  assign track2  = {ht_eff, 1'b0};

  logic adv, vout;
  assign adv       = !vout || res.ready;
  assign cmd.ready = adv;

  // stage 1: turn * half track product, measured rate signs
  logic        v1, en1, pneg1, clip1;
  logic [31:0] vx1, ml1, mr1;
  logic [62:0] pm1;
  logic [32:0] mlc, mrc;

  assign mlc = neg_sat(cmd.measured_left_motor_rate, left_sign_negative);
  assign mrc = neg_sat(cmd.measured_right_motor_rate, right_sign_negative);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= cmd.valid;
    if (adv) begin
      en1   <= cmd.enable;
      vx1   <= cmd.target_vx;
      pneg1 <= cmd.target_turn_rate[31];
      pm1   <= 63'(abs32(cmd.target_turn_rate)) * 63'(ht_eff);
      ml1   <= mlc[31:0];
      mr1   <= mrc[31:0];
      clip1 <= mlc[32] | mrc[32];
    end
  end

  // stage 2: round p, wheel radius products
  logic        v2, en2, lneg2, rneg2, clip2;
  logic [31:0] vx2, p2;
  logic [62:0] lmp2, rmp2;
  logic [62:0] pr;
  logic [32:0] pc;

  assign pr = pm1 + 63'h8000;
  assign pc = to_q(pneg1, 49'(pr[62:16]));

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      en2   <= en1;
      vx2   <= vx1;
      p2    <= pc[31:0];
      lmp2  <= 63'(abs32(ml1)) * 63'(rad_eff);
      rmp2  <= 63'(abs32(mr1)) * 63'(rad_eff);
      lneg2 <= ml1[31];
      rneg2 <= mr1[31];
      clip2 <= clip1 | (en1 & pc[32]);
    end
  end

  // stage 3: wheel speeds, measured linear speeds
  logic        v3, en3, clip3;
  logic [31:0] vl3, vr3, linl3, linr3;
  logic [32:0] vlc, vrc, llc, lrc;
  logic [62:0] lr_l, lr_r;

  assign vlc  = sat33({vx2[31], vx2} - {p2[31], p2});
  assign vrc  = sat33({vx2[31], vx2} + {p2[31], p2});
  assign lr_l = lmp2 + 63'h8000;
  assign lr_r = rmp2 + 63'h8000;
  assign llc  = to_q(lneg2, 49'(lr_l[62:16]));
  assign lrc  = to_q(rneg2, 49'(lr_r[62:16]));

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      en3   <= en2;
      vl3   <= vlc[31:0];
      vr3   <= vrc[31:0];
      linl3 <= llc[31:0];
      linr3 <= lrc[31:0];
      clip3 <= clip2 | (en2 & (vlc[32] | vrc[32])) | llc[32] | lrc[32];
    end
  end

  // stage 4: limit test and products, measured sum and difference
  logic        v4, en4, lim4, dneg4, clip4;
  logic [31:0] vl4, vr4, m4, mvx4;
  logic [62:0] prodl4, prodr4;
  logic [DIV_NW-1:0] nmw4;
  logic [31:0] avl, avr, mx;
  logic [32:0] dm;

  assign avl = abs32(vl3);
  assign avr = abs32(vr3);
  assign mx  = (avl > avr) ? avl : avr;
  assign dm  = {linr3[31], linr3} - {linl3[31], linl3};

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      en4    <= en3;
      vl4    <= vl3;
      vr4    <= vr3;
      m4     <= mx;
      lim4   <= en3 && (speed_limit != '0) && (mx > 32'(speed_limit));
      prodl4 <= 63'(avl) * 63'(speed_limit);
      prodr4 <= 63'(avr) * 63'(speed_limit);
      mvx4   <= half_sum(linl3, linr3);
      nmw4   <= DIV_NW'({abs33(dm), 16'd0}) + DIV_NW'(ht_eff);
      dneg4  <= dm[32];
      clip4  <= clip3;
    end
  end

  // stage 5: rounded limit numerators
  sb1_t              s5;
  logic [DIV_NW-1:0] lnl5, lnr5;
  logic [31:0]       m5;

  always_ff @(posedge clk) begin
    if (rst) s5.v <= 1'b0;
    else if (adv) s5.v <= v4;
    if (adv) begin
      s5.en   <= en4;
      s5.vl   <= vl4;
      s5.vr   <= vr4;
      s5.lim  <= lim4;
      s5.mvx  <= mvx4;
      s5.nmw  <= nmw4;
      s5.dneg <= dneg4;
      s5.clip <= clip4;
      m5      <= m4;
      lnl5    <= DIV_NW'(prodl4) + DIV_NW'(m4[31:1]);
      lnr5    <= DIV_NW'(prodr4) + DIV_NW'(m4[31:1]);
    end
  end

  // first divider pass: limit scaling
  logic [DIV_QW-1:0] q1l, q1r;
  sb1_t              sb1 [DIV_QW];

  ddk_div u_div_liml (.clk(clk), .adv(adv), .num(lnl5), .den(DIV_DW'(m5)),
                      .quo(q1l), .ovf());
  ddk_div u_div_limr (.clk(clk), .adv(adv), .num(lnr5), .den(DIV_DW'(m5)),
                      .quo(q1r), .ovf());

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_QW; k++) sb1[k].v <= 1'b0;
    end else if (adv) begin
      sb1[0] <= s5;
      for (int k = 1; k < DIV_QW; k++) sb1[k] <= sb1[k-1];
    end
  end

  // stage 6: select limited speeds
  sb1_t s6;

  always_ff @(posedge clk) begin
    if (rst) s6.v <= 1'b0;
    else if (adv) s6.v <= sb1[DIV_QW-1].v;
    if (adv) begin
      s6.en   <= sb1[DIV_QW-1].en;
      s6.lim  <= sb1[DIV_QW-1].lim;
      s6.mvx  <= sb1[DIV_QW-1].mvx;
      s6.nmw  <= sb1[DIV_QW-1].nmw;
      s6.dneg <= sb1[DIV_QW-1].dneg;
      s6.clip <= sb1[DIV_QW-1].clip;
      if (sb1[DIV_QW-1].lim) begin
        s6.vl <= sb1[DIV_QW-1].vl[31] ? 32'd0 - q1l : q1l;
        s6.vr <= sb1[DIV_QW-1].vr[31] ? 32'd0 - q1r : q1r;
      end else begin
        s6.vl <= sb1[DIV_QW-1].vl;
        s6.vr <= sb1[DIV_QW-1].vr;
      end
    end
  end

  // stage 7: numerators for the second pass, resolved vx
  sb2_t              s7;
  logic [DIV_NW-1:0] nl7, nr7, nw7, nmw7;
  logic [32:0]       dr;

  assign dr = {s6.vr[31], s6.vr} - {s6.vl[31], s6.vl};

  always_ff @(posedge clk) begin
    if (rst) s7.v <= 1'b0;
    else if (adv) s7.v <= s6.v;
    if (adv) begin
      s7.en   <= s6.en;
      s7.lneg <= s6.vl[31];
      s7.rneg <= s6.vr[31];
      s7.wneg <= dr[32];
      s7.rvx  <= half_sum(s6.vl, s6.vr);
      s7.mvx  <= s6.mvx;
      s7.dneg <= s6.dneg;
      s7.clip <= s6.clip;
      nl7     <= DIV_NW'({abs32(s6.vl), 16'd0}) + DIV_NW'(rad_eff[CFG_W-1:1]);
      nr7     <= DIV_NW'({abs32(s6.vr), 16'd0}) + DIV_NW'(rad_eff[CFG_W-1:1]);
      nw7     <= DIV_NW'({abs33(dr), 16'd0}) + DIV_NW'(ht_eff);
      nmw7    <= s6.nmw;
    end
  end

  // second divider pass
  logic [DIV_QW-1:0] qtl, qtr, qw, qmw;
  logic              otl, otr, ow, omw;
  sb2_t              sb2 [DIV_QW];

  ddk_div u_div_tgtl (.clk(clk), .adv(adv), .num(nl7), .den(DIV_DW'(rad_eff)),
                      .quo(qtl), .ovf(otl));
  ddk_div u_div_tgtr (.clk(clk), .adv(adv), .num(nr7), .den(DIV_DW'(rad_eff)),
                      .quo(qtr), .ovf(otr));
  ddk_div u_div_resw (.clk(clk), .adv(adv), .num(nw7), .den(DIV_DW'(track2)),
                      .quo(qw), .ovf(ow));
  ddk_div u_div_measw (.clk(clk), .adv(adv), .num(nmw7), .den(DIV_DW'(track2)),
                       .quo(qmw), .ovf(omw));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_QW; k++) sb2[k].v <= 1'b0;
    end else if (adv) begin
      sb2[0] <= s7;
      for (int k = 1; k < DIV_QW; k++) sb2[k] <= sb2[k-1];
    end
  end

  // output stage: saturate quotients, mounting signs
  sb2_t        f;
  logic [32:0] tlc, trc, tls, trs, wc, mwc;

  assign f   = sb2[DIV_QW-1];
  assign tlc = to_q(f.lneg, otl ? '1 : 49'(qtl));
  assign trc = to_q(f.rneg, otr ? '1 : 49'(qtr));
  assign tls = neg_sat(tlc[31:0], left_sign_negative);
  assign trs = neg_sat(trc[31:0], right_sign_negative);
  assign wc  = to_q(f.wneg, ow ? '1 : 49'(qw));
  assign mwc = to_q(f.dneg, omw ? '1 : 49'(qmw));

  logic [31:0] o_lt, o_rt, o_rvx, o_rw, o_mvx, o_mw;
  logic        o_en, o_sat;

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (adv) vout <= f.v;
    if (adv) begin
      o_en  <= f.en;
      o_lt  <= f.en ? tls[31:0] : '0;
      o_rt  <= f.en ? trs[31:0] : '0;
      o_rvx <= f.en ? f.rvx : '0;
      o_rw  <= f.en ? wc[31:0] : '0;
      o_mvx <= f.mvx;
      o_mw  <= mwc[31:0];
      o_sat <= f.clip | mwc[32] |
               (f.en & (tlc[32] | trc[32] | tls[32] | trs[32] | wc[32]));
    end
  end

  assign res.valid              = vout;
  assign res.left_motor_target  = o_lt;
  assign res.right_motor_target = o_rt;
  assign res.motors_enabled     = o_en;
  assign res.resolved_vx        = o_rvx;
  assign res.resolved_turn_rate = o_rw;
  assign res.measured_vx        = o_mvx;
  assign res.measured_turn_rate = o_mw;
  assign res.saturated          = o_sat;

endmodule
`default_nettype wire

// File: src/ddk_checker.sv
// Checker: port-level properties of the kinematics block, bound to the top level.
`default_nettype none
module ddk_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_en,
  input logic [31:0] res_lt,
  input logic [31:0] res_rt,
  input logic [31:0] res_rvx,
  input logic [31:0] res_rw,
  input logic        res_sat
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_lt) && $stable(res_rt) &&
    $stable(res_sat))
    else $error("stalled result beat changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    cmd_ready == (!res_valid || res_ready))
    else $error("input ready does not follow output stall");

  a_disabled: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_en |-> res_lt == 32'd0 && res_rt == 32'd0 &&
    res_rvx == 32'd0 && res_rw == 32'd0)
    else $error("disabled beat with nonzero targets");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind diff_drive_kinematics ddk_checker u_ddk_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_en    (res.motors_enabled),
  .res_lt    (res.left_motor_target),
  .res_rt    (res.right_motor_target),
  .res_rvx   (res.resolved_vx),
  .res_rw    (res.resolved_turn_rate),
  .res_sat   (res.saturated)
);
`default_nettype wire
